>>> src/bkp_pkg.sv
// bkp_pkg: shared types and constants for the button triggered key playback block
// no dependencies; imported by the core and the top level
`timescale 1ns / 1ps

package bkp_pkg;

	// widths of the configuration registers and state
	localparam int unsigned TRIGGER_W = 16;
	localparam int unsigned MASK_W    = 8;
	localparam int unsigned WINDOW_W  = 16;
	localparam int unsigned KEYSEQ_W  = 32;
	localparam int unsigned TICKS_W   = 16;
	localparam int unsigned INDEX_W   = 4;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// number of keys in one playback sequence (1 to 4)
	localparam int unsigned KEY_COUNT = 4;

	// play index value at which playback ends: one press and one release per key
	localparam logic [INDEX_W-1:0] PLAY_END = INDEX_W'(2 * KEY_COUNT);

	// reset values of the configuration registers
	localparam logic [TRIGGER_W-1:0] TRIGGER_MS_RST  = 16'd750;
	localparam logic [MASK_W-1:0]    LOCK_MASK_RST   = 8'h04;
	localparam logic [WINDOW_W-1:0]  WINDOW_LOW_RST  = 16'd800;
	localparam logic [WINDOW_W-1:0]  WINDOW_HIGH_RST = 16'd1200;
	localparam logic [KEYSEQ_W-1:0]  KEY_SEQ_RST     = 32'h0706_0504;

	// saturation value of the lock duration counter
	localparam logic [TICKS_W-1:0] LOCK_TICKS_MAX = 16'hFFFF;

	// event codes on the input channel
	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_SLOT = 2'd1,
		OP_LOCK = 2'd2
	} op_t;

	// playback phase
	typedef enum logic [1:0] {
		PH_COOLDOWN = 2'd0,
		PH_ARMED    = 2'd1,
		PH_TRANSMIT = 2'd2
	} phase_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRIGGER_MS   = 3'd0,
		REG_LOCK_MASK    = 3'd1,
		REG_WINDOW_LOW   = 3'd2,
		REG_WINDOW_HIGH  = 3'd3,
		REG_KEY_SEQUENCE = 3'd4
	} reg_idx_t;

	// configuration handed to the core
	typedef struct packed {
		logic [TRIGGER_W-1:0] trigger_ms;
		logic [MASK_W-1:0]    lock_mask;
		logic [WINDOW_W-1:0]  window_low;
		logic [WINDOW_W-1:0]  window_high;
		logic [KEYSEQ_W-1:0]  key_sequence;
	} cfg_t;

	// one result beat
	typedef struct packed {
		logic [BYTE_W-1:0] key_code;
		phase_t            phase;
		logic              reboot_request;
	} res_t;

endpackage

>>> src/bkp_if.sv
// bkp_if: valid/ready channel interfaces for input events and results
// depends on nothing; payload widths follow the event and result formats
`timescale 1ns / 1ps

// input event channel
interface bkp_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic       button_level;
	logic [7:0] lock_byte;

	modport source (output valid, output opcode, output button_level, output lock_byte,
		input ready);
	modport sink (input valid, input opcode, input button_level, input lock_byte,
		output ready);
endinterface

// result channel
interface bkp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_code;
	logic [1:0] phase;
	logic       reboot_request;

	modport source (output valid, output key_code, output phase, output reboot_request,
		input ready);
	modport sink (input valid, input key_code, input phase, input reboot_request,
		output ready);
endinterface

>>> src/button_triggered_key_playback.sv
// button_triggered_key_playback: top level with configuration registers and result register
// depends on bkp_pkg, bkp_if (bkp_in_if, bkp_out_if) and bkp_core
//
// Usage: the item channel carries one event per beat: a millisecond tick with the
// button level, a report slot, or a received lock byte. Every accepted beat gives
// exactly one result beat on the result channel: the key code for a report slot
// (zero for a release slot, a slot outside playback or any other event), the phase
// after the event and the sticky reboot request.
// The result of an accepted beat is registered and is valid in the following cycle.
// Throughput is one beat per cycle while the receiver is ready; the state update and the
// result fit between the input handshake and the single result register.
// When the receiver stalls, the held result stays in the result register and the
// item channel stays ready only while that register is empty or being emptied in the same
// cycle, so nothing is lost or repeated.
// Reset (arst_n low) puts the block in cooldown with the hold counter at 750, clears
// the lock timer, the stored lock byte and the reboot request, and restores the
// register defaults. The user must write registers through cfg_we/cfg_index/cfg_data only
// while the block is idle; the block does not enforce it. Unknown indexes are ignored.
`timescale 1ns / 1ps

module button_triggered_key_playback (
	input  logic                              clk,
	input  logic                              arst_n,
	bkp_in_if.sink                            item,
	bkp_out_if.source                         result,
	input  logic                              cfg_we,
	input  logic [bkp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bkp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import bkp_pkg::*;

	cfg_t cfg_q;
	res_t res_d;
	res_t res_q;
	logic out_valid_q;
	logic accept;

	// handshake: ready while the result register is empty or being drained
	assign item.ready = !out_valid_q || result.ready;
	assign accept     = item.valid && item.ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_ms   <= TRIGGER_MS_RST;
			cfg_q.lock_mask    <= LOCK_MASK_RST;
			cfg_q.window_low   <= WINDOW_LOW_RST;
			cfg_q.window_high  <= WINDOW_HIGH_RST;
			cfg_q.key_sequence <= KEY_SEQ_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TRIGGER_MS:   cfg_q.trigger_ms   <= cfg_data[TRIGGER_W-1:0];
				REG_LOCK_MASK:    cfg_q.lock_mask    <= cfg_data[MASK_W-1:0];
				REG_WINDOW_LOW:   cfg_q.window_low   <= cfg_data[WINDOW_W-1:0];
				REG_WINDOW_HIGH:  cfg_q.window_high  <= cfg_data[WINDOW_W-1:0];
				REG_KEY_SEQUENCE: cfg_q.key_sequence <= cfg_data[KEYSEQ_W-1:0];
				default: ;
			endcase
		end
	end

	// event processing
	bkp_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.opcode       (item.opcode),
		.button_level (item.button_level),
		.lock_byte    (item.lock_byte),
		.cfg          (cfg_q),
		.res          (res_d)
	);

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.key_code       = res_q.key_code;
	assign result.phase          = res_q.phase;
	assign result.reboot_request = res_q.reboot_request;

endmodule

>>> src/bkp_core.sv
// bkp_core: playback phase machine, hold counter, lock timer and reboot latch
// depends on bkp_pkg; the result of the current beat is produced combinationally
`timescale 1ns / 1ps

module bkp_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [1:0]                    opcode,
	input  logic                          button_level,
	input  logic [bkp_pkg::BYTE_W-1:0]    lock_byte,
	input  bkp_pkg::cfg_t                 cfg,
	output bkp_pkg::res_t                 res
);
	import bkp_pkg::*;

	phase_t               phase_q, phase_d;
	logic [TRIGGER_W-1:0] hold_q, hold_d;
	logic [INDEX_W-1:0]   index_q, index_d;
	logic [TICKS_W-1:0]   ticks_q, ticks_d;
	logic [BYTE_W-1:0]    prev_lock_q, prev_lock_d;
	logic                 reboot_q, reboot_d;

	logic [INDEX_W-1:0]   index_inc;
	logic                 lock_on;
	logic                 in_window;
	logic [BYTE_W-1:0]    key_d;

	assign index_inc = index_q + INDEX_W'(1);
	assign lock_on   = |(prev_lock_q & cfg.lock_mask);
	assign in_window = (ticks_q > cfg.window_low) && (ticks_q < cfg.window_high);

	// next state
	always_comb begin
		phase_d     = phase_q;
		hold_d      = hold_q;
		index_d     = index_q;
		ticks_d     = ticks_q;
		prev_lock_d = prev_lock_q;
		reboot_d    = reboot_q;
		if (accept) begin
			case (opcode)
				OP_TICK: begin
					// button is ignored during playback
					if (phase_q != PH_TRANSMIT) begin
						if (button_level) begin
							if (hold_q != '0) hold_d = hold_q - TRIGGER_W'(1);
							else phase_d = PH_ARMED;
						end else if (hold_q < cfg.trigger_ms) begin
							hold_d = hold_q + TRIGGER_W'(1);
						end else if (phase_q == PH_ARMED) begin
							phase_d = PH_TRANSMIT;
							index_d = '0;
						end
					end
					// saturating lock duration
					if (lock_on && ticks_q != LOCK_TICKS_MAX) ticks_d = ticks_q + TICKS_W'(1);
				end
				OP_SLOT: begin
					if (phase_q == PH_TRANSMIT) begin
						index_d = index_inc;
						if (index_inc >= PLAY_END) phase_d = PH_COOLDOWN;
					end
				end
				OP_LOCK: begin
					if (lock_byte != prev_lock_q) begin
						if (in_window) reboot_d = 1'b1;
						ticks_d     = '0;
						prev_lock_d = lock_byte;
					end
				end
				default: ;
			endcase
		end
	end

	// key for a report slot: even index presses, odd index releases
	always_comb begin
		key_d = '0;
		if (opcode == OP_SLOT && phase_q == PH_TRANSMIT && !index_q[0])
			key_d = cfg.key_sequence[{index_q[2:1], 3'b000} +: BYTE_W];
	end

	// result fields reflect the state after this beat
	always_comb begin
		res.key_code       = key_d;
		res.phase          = phase_d;
		res.reboot_request = reboot_d;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_COOLDOWN;
			hold_q      <= TRIGGER_MS_RST;
			index_q     <= '0;
			ticks_q     <= '0;
			prev_lock_q <= '0;
			reboot_q    <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			hold_q      <= hold_d;
			index_q     <= index_d;
			ticks_q     <= ticks_d;
			prev_lock_q <= prev_lock_d;
			reboot_q    <= reboot_d;
		end
	end

	// reboot request is sticky
	a_reboot_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(reboot_q))
		else $error("reboot request cleared");

	// play index never runs past the end of the sequence
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		index_q <= PLAY_END)
		else $error("play index beyond sequence end");

	// a changed lock byte restarts the lock timer
	a_lock_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_LOCK && lock_byte != prev_lock_q) |=> ticks_q == '0)
		else $error("lock timer not restarted");

	// state only moves on an accepted beat
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> ($stable(hold_q) && $stable(phase_q) && $stable(ticks_q)))
		else $error("state changed without a beat");

endmodule

>>> bench/tb_top.sv
// tb_top: self-checking bench for button_triggered_key_playback, event beats in, result beats out
// depends on bkp_pkg, bkp_in_if / bkp_out_if and the button_triggered_key_playback top level
// a built-in predictor checks every result beat; idling, a long result hold-off and config phases
`timescale 1ns / 1ps

module tb_top;
	import bkp_pkg::*;

	// event code with no meaning to the block
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// ways of picking a configuration
	localparam int CFG_RANDOM  = 0;
	localparam int CFG_ALL_MIN = 1;
	localparam int CFG_ALL_MAX = 2;

	typedef struct packed {
		logic [1:0] opcode;
		logic       button_level;
		logic [7:0] lock_byte;
	} event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// driven values, all known from the start
	logic                  in_valid = 1'b0;
	logic [1:0]            in_opcode = OP_TICK;
	logic                  in_level = 1'b1;
	logic [7:0]            in_lock = '0;
	logic                  out_ready = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_TRIGGER_MS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bkp_in_if  item_ch ();
	bkp_out_if res_ch ();

	assign item_ch.valid        = in_valid;
	assign item_ch.opcode       = in_opcode;
	assign item_ch.button_level = in_level;
	assign item_ch.lock_byte    = in_lock;
	assign res_ch.ready         = out_ready;

	button_triggered_key_playback DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// stimulus and expectation stores
	event_t      event_q[$];
	res_t        key_result_q[$];
	res_t        mon_want;
	event_t      drv_ev;
	int unsigned send_idle = 34;
	int unsigned recv_idle = 60;
	int unsigned fail_count = 0;
	bit          stall_arm = 1'b0;
	logic        stall_on = 1'b0;
	logic [7:0]  gen_last_lock = '0;

	// predictor state and its copy of the registers
	cfg_t                 mdl_cfg;
	phase_t               mdl_phase;
	logic [TRIGGER_W-1:0] mdl_hold;
	logic [INDEX_W-1:0]   mdl_play_idx;
	logic [TICKS_W-1:0]   mdl_lock_ticks;
	logic [BYTE_W-1:0]    mdl_last_lock;
	logic                 mdl_reboot;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void reset_playback_model();
		mdl_cfg.trigger_ms   = TRIGGER_MS_RST;
		mdl_cfg.lock_mask    = LOCK_MASK_RST;
		mdl_cfg.window_low   = WINDOW_LOW_RST;
		mdl_cfg.window_high  = WINDOW_HIGH_RST;
		mdl_cfg.key_sequence = KEY_SEQ_RST;
		mdl_phase      = PH_COOLDOWN;
		mdl_hold       = TRIGGER_MS_RST;
		mdl_play_idx   = '0;
		mdl_lock_ticks = '0;
		mdl_last_lock  = '0;
		mdl_reboot     = 1'b0;
	endfunction

	// advance the predictor by one event and give the result beat it should cause
	function automatic res_t playback_predict(logic [1:0] op, logic lvl, logic [7:0] lb);
		res_t       r;
		logic [7:0] key;
		key = '0;
		case (op)
			OP_TICK: begin
				// button ignored while keys are being sent
				if (mdl_phase != PH_TRANSMIT) begin
					if (lvl) begin
						if (mdl_hold != '0)
							mdl_hold = mdl_hold - 1'b1;
						else
							mdl_phase = PH_ARMED;
					end else if (mdl_hold < mdl_cfg.trigger_ms) begin
						mdl_hold = mdl_hold + 1'b1;
					end else if (mdl_phase == PH_ARMED) begin
						mdl_phase    = PH_TRANSMIT;
						mdl_play_idx = '0;
					end
				end
				if ((mdl_last_lock & mdl_cfg.lock_mask) != '0 && mdl_lock_ticks != LOCK_TICKS_MAX)
					mdl_lock_ticks = mdl_lock_ticks + 1'b1;
			end
			OP_SLOT: begin
				// even slots press the next key, odd slots release it
				if (mdl_phase == PH_TRANSMIT) begin
					if (!mdl_play_idx[0])
						key = mdl_cfg.key_sequence[8 * mdl_play_idx[2:1] +: 8];
					mdl_play_idx = mdl_play_idx + 1'b1;
					if (mdl_play_idx >= PLAY_END)
						mdl_phase = PH_COOLDOWN;
				end
			end
			OP_LOCK: begin
				if (lb != mdl_last_lock) begin
					if (mdl_lock_ticks > mdl_cfg.window_low && mdl_lock_ticks < mdl_cfg.window_high)
						mdl_reboot = 1'b1;
					mdl_lock_ticks = '0;
					mdl_last_lock  = lb;
				end
			end
			default: ;
		endcase
		r.key_code       = key;
		r.phase          = mdl_phase;
		r.reboot_request = mdl_reboot;
		return r;
	endfunction

	// driver: predict each accepted beat, then offer the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && item_ch.ready)
				key_result_q.push_back(playback_predict(in_opcode, in_level, in_lock));
			if (!in_valid || item_ch.ready) begin
				if (event_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					drv_ev = event_q.pop_front();
					in_valid  <= 1'b1;
					in_opcode <= drv_ev.opcode;
					in_level  <= drv_ev.button_level;
					in_lock   <= drv_ev.lock_byte;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && out_ready) begin
				if (key_result_q.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual key %0h phase %0d flag %0b",
						$time, res_ch.key_code, res_ch.phase, res_ch.reboot_request);
					fail_count++;
				end else begin
					mon_want = key_result_q.pop_front();
					if (res_ch.key_code !== mon_want.key_code) begin
						$display("%0t: key_code expected %0h actual %0h",
							$time, mon_want.key_code, res_ch.key_code);
						fail_count++;
					end
					if (res_ch.phase !== mon_want.phase) begin
						$display("%0t: phase expected %0d actual %0d",
							$time, mon_want.phase, res_ch.phase);
						fail_count++;
					end
					if (res_ch.reboot_request !== mon_want.reboot_request) begin
						$display("%0t: reboot_request expected %0b actual %0b",
							$time, mon_want.reboot_request, res_ch.reboot_request);
						fail_count++;
					end
				end
			end
			out_ready <= stall_on ? 1'b0 : ($urandom_range(99) >= recv_idle);
		end
	end

	// long result hold-off while the sender keeps offering beats
	initial begin
		wait (stall_arm);
		repeat (20) @(posedge clk);
		stall_on <= 1'b1;
		repeat (400) @(posedge clk);
		stall_on <= 1'b0;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("[button_triggered_key_playback] ERROR");
		$finish;
	end

	task automatic push_event(logic [1:0] op, logic lvl, logic [7:0] lb);
		event_t ev;
		ev.opcode       = op;
		ev.button_level = lvl;
		ev.lock_byte    = lb;
		event_q.push_back(ev);
		if (op == OP_LOCK)
			gen_last_lock = lb;
	endtask

	task automatic push_ticks(int n, logic lvl);
		repeat (n) push_event(OP_TICK, lvl, 8'($urandom));
	endtask

	task automatic push_slots(int n);
		repeat (n) push_event(OP_SLOT, 1'($urandom), 8'($urandom));
	endtask

	// wait until every beat has gone through and the result register is empty
	task automatic wait_quiet();
		while (event_q.size() != 0 || key_result_q.size() != 0 || in_valid)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
	endtask

	task automatic write_config(cfg_t c);
		write_reg(REG_TRIGGER_MS, CFG_DATA_W'(c.trigger_ms));
		write_reg(REG_LOCK_MASK, CFG_DATA_W'(c.lock_mask));
		write_reg(REG_WINDOW_LOW, CFG_DATA_W'(c.window_low));
		write_reg(REG_WINDOW_HIGH, CFG_DATA_W'(c.window_high));
		write_reg(REG_KEY_SEQUENCE, CFG_DATA_W'(c.key_sequence));
		@(posedge clk);
		cfg_we <= 1'b0;
		mdl_cfg = c;
		@(negedge clk);
	endtask

	// mostly short triggers and small windows so that playback and requests happen often
	function automatic cfg_t pick_config(int mode);
		cfg_t c;
		if (mode == CFG_ALL_MIN) begin
			c = '0;
		end else if (mode == CFG_ALL_MAX) begin
			c = '1;
		end else begin
			case ($urandom_range(9))
				0: c.trigger_ms = '0;
				1: c.trigger_ms = '1;
				default: c.trigger_ms = TRIGGER_W'($urandom_range(1, 10));
			endcase
			case ($urandom_range(9))
				0: c.lock_mask = '0;
				1: c.lock_mask = '1;
				2, 3: c.lock_mask = MASK_W'($urandom);
				default: c.lock_mask = MASK_W'(1) << $urandom_range(7);
			endcase
			case ($urandom_range(9))
				0: c.window_low = '0;
				1: c.window_low = '1;
				default: c.window_low = WINDOW_W'($urandom_range(0, 15));
			endcase
			case ($urandom_range(9))
				0: c.window_high = '0;
				1: c.window_high = '1;
				default: c.window_high = WINDOW_W'($urandom_range(0, 30));
			endcase
			case ($urandom_range(9))
				0: c.key_sequence = '0;
				1: c.key_sequence = '1;
				default: c.key_sequence = KEYSEQ_W'($urandom);
			endcase
		end
		return c;
	endfunction

	// one stretch of random traffic under the current registers
	task automatic queue_session(input int target, output int count);
		int         kind;
		int         len;
		int         lim;
		logic [7:0] b;
		count = 0;
		lim = (mdl_cfg.trigger_ms > 12) ? 12 : int'(mdl_cfg.trigger_ms);
		while (count < target) begin
			kind = $urandom_range(99);
			if (kind < 20) begin
				// finish any playback, re-arm, hold, then read out the keys
				len = lim + 2;
				push_slots(9);
				push_ticks(len, 1'b1);
				push_ticks(len, 1'b0);
				push_slots(9);
				count += 2 * len + 18;
			end else if (kind < 40) begin
				len = $urandom_range(0, lim + 4);
				push_ticks(len, 1'b1);
				count += len;
			end else if (kind < 60) begin
				len = $urandom_range(0, lim + 4);
				push_ticks(len, 1'b0);
				count += len;
			end else if (kind < 75) begin
				len = $urandom_range(1, 10);
				push_slots(len);
				count += len;
			end else if (kind < 90) begin
				case ($urandom_range(3))
					0, 1: b = 8'($urandom);
					2: b = gen_last_lock ^ (8'd1 << $urandom_range(7));
					default: b = gen_last_lock;
				endcase
				push_event(OP_LOCK, 1'($urandom), b);
				count++;
			end else begin
				push_event(2'($urandom_range(3)), 1'($urandom), 8'($urandom));
				count++;
			end
		end
	endtask

	task automatic run_sessions(int total, int first_mode, int first_len);
		int done;
		int n;
		int mode;
		done = 0;
		mode = first_mode;
		n = first_len;
		while (done < total) begin
			wait_quiet();
			write_config(pick_config(mode));
			queue_session(n, n);
			done += n;
			mode = CFG_RANDOM;
			n = $urandom_range(40, 120);
		end
	endtask

	// stimulus
	initial begin
		cfg_t c;
		int   i;
		reset_playback_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// field extremes, every event code, slot outside playback, unchanged lock byte
		push_event(OP_TICK, 1'b0, 8'h00);
		push_event(OP_TICK, 1'b1, 8'hFF);
		push_event(OP_SLOT, 1'b0, 8'hFF);
		push_event(OP_SLOT, 1'b1, 8'h00);
		push_event(OP_UNUSED, 1'b1, 8'hFF);
		push_event(OP_UNUSED, 1'b0, 8'h00);
		push_event(OP_LOCK, 1'b1, 8'hFF);
		push_event(OP_LOCK, 1'b0, 8'hFF);
		push_event(OP_TICK, 1'b1, 8'h5A);
		push_event(OP_LOCK, 1'b0, 8'h00);
		push_event(OP_LOCK, 1'b1, 8'h04);

		// full playback with default registers; lock held for exactly the upper bound
		for (i = 0; i < 760; i++) begin
			if (i == 300)
				push_event(OP_LOCK, 1'b0, 8'h0C);
			push_event(OP_TICK, 1'b1, 8'($urandom));
		end
		for (i = 0; i < 760; i++) begin
			if (i == 740)
				push_event(OP_LOCK, 1'b1, 8'h08);
			push_event(OP_TICK, 1'b0, 8'($urandom));
		end
		push_slots(9);
		wait_quiet();

		// inverted window, then hold count left above a lowered trigger
		c.trigger_ms   = 16'd40;
		c.lock_mask    = 8'h01;
		c.window_low   = 16'd100;
		c.window_high  = 16'd50;
		c.key_sequence = 32'h00FF_8001;
		write_config(c);
		push_slots(8);
		push_ticks(10, 1'b1);
		push_event(OP_LOCK, 1'b0, 8'h01);
		push_ticks(20, 1'b0);
		push_event(OP_LOCK, 1'b0, 8'h00);
		wait_quiet();
		c.trigger_ms = 16'd5;
		write_config(c);
		push_ticks(1, 1'b0);
		push_slots(9);

		// random traffic in three idling regimes
		run_sessions(150, CFG_RANDOM, 80);
		wait_quiet();
		send_idle = 60;
		recv_idle = 34;
		run_sessions(150, CFG_ALL_MAX, 60);
		wait_quiet();
		send_idle = 0;
		recv_idle = 0;
		write_config(pick_config(CFG_ALL_MIN));
		stall_arm = 1'b1;
		queue_session(100, i);
		run_sessions(100, CFG_RANDOM, 80);

		wait_quiet();
		if (fail_count == 0)
			$display("[button_triggered_key_playback] OK");
		else
			$display("[button_triggered_key_playback] ERROR");
		$finish;
	end

endmodule

>>> filelist.f
src/bkp_pkg.sv
src/bkp_if.sv
src/bkp_core.sv
src/button_triggered_key_playback.sv
bench/tb_top.sv
